### rtl/core/ymfr_pkg.sv
// ymfr_pkg: shared types and constants of the ymodem frame receiver
// used by ymfr_core, ymfr_outq and ymodem_frame_receiver_top
package ymfr_pkg;

    localparam int NAME_SCAN_LIMIT = 128;
    localparam int LONG_BLOCK      = 1024;
    localparam int SHORT_BLOCK     = 128;

    localparam int OFF_W   = 11;
    localparam int RES_MAX = 3;
    localparam int NUM_W   = 2;

    localparam int BQ_DEPTH = 4;
    localparam int BQ_PTR_W = $clog2(BQ_DEPTH);
    localparam int BQ_LVL_W = $clog2(BQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_A_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_B_ADDR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CNT_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CNT_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CNT_DEF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSING_REPLY = 3'd6;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_C   = 8'h43;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  rx_byte;
        logic        frame_end;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [31:0] flash_addr;
        logic [15:0] sector_count;
    } t_res;

    typedef struct packed {
        t_res [RES_MAX-1:0] res;
        logic [NUM_W-1:0]   num;
        logic               success;
    } t_bundle;

endpackage

### rtl/core/ymodem_frame_receiver_top.sv
// ymodem_frame_receiver_top: top level of the ymodem frame receiver
// instantiates ymfr_core and ymfr_outq; depends on ymfr_pkg
//
// One request is taken per cycle while o_in_stall is low. A request is
// registered, decoded against the frame state in the next cycle, and its
// results (a flash write, an erase, reply bytes; at most three) enter a
// four-entry bundle queue as one bundle. Results leave one per cycle while
// i_out_stall is low; the input stalls only once the bundle queue plus the
// request in flight reach four entries. The user must write registers
// through the plain write port only while the block is idle, which the block
// itself does not enforce.
module ymodem_frame_receiver_top import ymfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_value,
    output logic [31:0]           o_flash_addr,
    output logic [15:0]           o_sector_count,
    output logic                  o_success,
    output logic                  o_last
);

    t_req                req;
    t_bundle             bundle;
    t_res                res;
    logic                push;
    logic [BQ_LVL_W-1:0] q_level;

    assign req.cmd       = i_cmd;
    assign req.rx_byte   = i_rx_byte;
    assign req.frame_end = i_frame_end;

    ymfr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_req      (req),
        .i_q_level  (q_level),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_bundle   (bundle)
    );

    ymfr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_bundle    (bundle),
        .i_out_stall (i_out_stall),
        .o_level     (q_level),
        .o_out_valid (o_out_valid),
        .o_res       (res),
        .o_success   (o_success),
        .o_last      (o_last)
    );

    assign o_kind         = res.kind;
    assign o_value        = res.value;
    assign o_flash_addr   = res.flash_addr;
    assign o_sector_count = res.sector_count;

endmodule

### rtl/core/ymfr_core.sv
// ymfr_core: configuration registers, request register and frame state machine
// produces one bundle of up to three results per request; depends on ymfr_pkg
module ymfr_core import ymfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_req                  i_req,
    input  logic [BQ_LVL_W-1:0]   i_q_level,
    output logic                  o_in_stall,
    output logic                  o_push,
    output t_bundle               o_bundle
);

    typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_EOT1, PH_CLOSE} t_phase;
    typedef enum logic [1:0] {PS_NAME, PS_DIGITS, PS_DONE} t_parse;

    localparam logic [OFF_W-1:0] OFF_MAX   = '1;
    localparam logic [OFF_W-1:0] OFF_DATA  = OFF_W'(3);
    localparam logic [OFF_W-1:0] NAME_LIM  = OFF_W'(NAME_SCAN_LIMIT);
    localparam logic [OFF_W-1:0] BLK_SHORT = OFF_W'(SHORT_BLOCK);
    localparam logic [OFF_W-1:0] BLK_LONG  = OFF_W'(LONG_BLOCK);

    logic [31:0] r_target_addr, r_slot_a_addr, r_slot_b_addr;
    logic [15:0] r_erase_cnt_a, r_erase_cnt_b, r_erase_cnt_def;
    logic [7:0]  r_closing_reply;

    logic        r_in_valid;
    t_req        r_in;

    t_phase           r_phase, n_phase;
    t_parse           r_parse, n_parse;
    logic [OFF_W-1:0] r_frame_offset, n_frame_offset;
    logic [7:0]       r_frame_type, n_frame_type;
    logic [31:0]      r_write_addr, n_write_addr;
    logic [31:0]      r_bytes_done, n_bytes_done;
    logic [31:0]      r_file_size, n_file_size;
    logic [OFF_W-1:0] r_write_limit, n_write_limit;
    logic             r_done, n_done;

    logic [31:0]      rem;
    logic [OFF_W-1:0] blk;
    logic [OFF_W-1:0] lim;
    logic [OFF_W-1:0] idx;
    logic [15:0]      erase_cnt;
    logic             is_digit;
    logic             has_wr;
    t_res             wr_res;
    t_res [RES_MAX-1:0] end_res;
    logic [NUM_W-1:0] end_num;
    logic             in_accept;

    // backpressure: room for the registered request and this one
    assign o_in_stall = ({1'b0, i_q_level} + (BQ_LVL_W+1)'(r_in_valid))
                        >= (BQ_LVL_W+1)'(BQ_DEPTH);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign rem      = r_file_size - r_bytes_done;
    assign blk      = (r_in.rx_byte == B_SOH) ? BLK_SHORT : BLK_LONG;
    assign lim      = (rem < {{(32-OFF_W){1'b0}}, blk}) ? rem[OFF_W-1:0] : blk;
    assign idx      = r_frame_offset - OFF_DATA;
    assign is_digit = (r_in.rx_byte >= CH_0) && (r_in.rx_byte <= CH_9);

    always_comb begin
        if (r_target_addr == r_slot_a_addr) begin
            erase_cnt = r_erase_cnt_a;
        end else if (r_target_addr == r_slot_b_addr) begin
            erase_cnt = r_erase_cnt_b;
        end else begin
            erase_cnt = r_erase_cnt_def;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_parse        = r_parse;
        n_frame_offset = r_frame_offset;
        n_frame_type   = r_frame_type;
        n_write_addr   = r_write_addr;
        n_bytes_done   = r_bytes_done;
        n_file_size    = r_file_size;
        n_write_limit  = r_write_limit;
        n_done         = r_done;
        has_wr         = 1'b0;
        wr_res         = '0;
        end_res        = '0;
        end_num        = '0;

        if (r_in_valid) begin
            if (r_in.cmd) begin
                n_phase        = PH_HEADER;
                n_done         = 1'b0;
                n_bytes_done   = '0;
                n_frame_offset = '0;
                n_parse        = PS_NAME;
                n_write_limit  = '0;
            end else begin
                // per-byte work
                if (r_frame_offset == '0) begin
                    n_frame_type  = r_in.rx_byte;
                    n_write_limit = '0;
                    if (r_phase == PH_HEADER && r_in.rx_byte == B_SOH) begin
                        n_file_size = '0;
                        n_parse     = PS_NAME;
                    end
                    if (r_phase == PH_DATA &&
                        (r_in.rx_byte == B_SOH || r_in.rx_byte == B_STX)) begin
                        n_write_limit = lim;
                    end
                end else if (r_frame_offset >= OFF_DATA) begin
                    if (r_phase == PH_HEADER && r_frame_type == B_SOH) begin
                        case (r_parse)
                            PS_NAME: begin
                                if (r_in.rx_byte == 8'h00 || idx >= NAME_LIM) begin
                                    n_parse = PS_DIGITS;
                                end
                            end
                            PS_DIGITS: begin
                                if (is_digit) begin
                                    n_file_size = (r_file_size << 3) + (r_file_size << 1)
                                                  + {24'd0, r_in.rx_byte - CH_0};
                                end else begin
                                    n_parse = PS_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end else if (r_phase == PH_DATA &&
                                 (r_frame_type == B_SOH || r_frame_type == B_STX)) begin
                        if (idx < r_write_limit) begin
                            has_wr            = 1'b1;
                            wr_res.kind       = KIND_WRITE;
                            wr_res.value      = r_in.rx_byte;
                            wr_res.flash_addr = r_write_addr;
                            n_write_addr      = r_write_addr + 32'd1;
                            n_bytes_done      = r_bytes_done + 32'd1;
                        end
                    end
                end

                // end of frame
                if (r_in.frame_end) begin
                    unique case (r_phase)
                        PH_HEADER: begin
                            if (n_frame_type == B_SOH) begin
                                n_write_addr            = r_target_addr;
                                n_bytes_done            = '0;
                                end_res[0].kind         = KIND_ERASE;
                                end_res[0].flash_addr   = r_target_addr;
                                end_res[0].sector_count = erase_cnt;
                                end_res[1].kind         = KIND_REPLY;
                                end_res[1].value        = B_ACK;
                                end_res[2].kind         = KIND_REPLY;
                                end_res[2].value        = B_C;
                                end_num                 = NUM_W'(3);
                                n_phase                 = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (n_frame_type == B_SOH || n_frame_type == B_STX) begin
                                end_res[0].kind  = KIND_REPLY;
                                end_res[0].value = B_ACK;
                                end_num          = NUM_W'(1);
                            end else if (n_frame_type == B_EOT) begin
                                end_res[0].kind  = KIND_REPLY;
                                end_res[0].value = B_NAK;
                                end_num          = NUM_W'(1);
                                n_phase          = PH_EOT1;
                            end else begin
                                n_phase = PH_HEADER;
                                n_done  = 1'b0;
                            end
                        end
                        PH_EOT1: begin
                            if (n_frame_type == B_EOT) begin
                                n_done           = 1'b1;
                                end_res[0].kind  = KIND_REPLY;
                                end_res[0].value = B_ACK;
                                end_res[1].kind  = KIND_REPLY;
                                end_res[1].value = B_C;
                                end_num          = NUM_W'(2);
                                n_phase          = PH_CLOSE;
                            end
                        end
                        PH_CLOSE: begin
                            if (n_frame_type == B_SOH) begin
                                end_res[0].kind  = KIND_REPLY;
                                end_res[0].value = B_ACK;
                                end_res[1].kind  = KIND_REPLY;
                                end_res[1].value = r_closing_reply;
                                end_num          = NUM_W'(2);
                            end
                            n_phase = PH_HEADER;
                        end
                        default: ;
                    endcase
                    n_frame_offset = '0;
                end else if (r_frame_offset < OFF_MAX) begin
                    n_frame_offset = r_frame_offset + OFF_W'(1);
                end
            end
        end
    end

    // write result goes ahead of the end-of-frame results
    always_comb begin
        o_bundle.res[0]  = has_wr ? wr_res     : end_res[0];
        o_bundle.res[1]  = has_wr ? end_res[0] : end_res[1];
        o_bundle.res[2]  = has_wr ? end_res[1] : end_res[2];
        o_bundle.num     = end_num + NUM_W'(has_wr);
        o_bundle.success = n_done;
    end

    assign o_push = r_in_valid && !r_in.cmd && (o_bundle.num != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_addr   <= '0;
            r_slot_a_addr   <= '0;
            r_slot_b_addr   <= '0;
            r_erase_cnt_a   <= 16'd20;
            r_erase_cnt_b   <= 16'd20;
            r_erase_cnt_def <= 16'd20;
            r_closing_reply <= 8'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_ADDR:   r_target_addr   <= i_cfg_data;
                CFG_SLOT_A_ADDR:   r_slot_a_addr   <= i_cfg_data;
                CFG_SLOT_B_ADDR:   r_slot_b_addr   <= i_cfg_data;
                CFG_ERASE_CNT_A:   r_erase_cnt_a   <= i_cfg_data[15:0];
                CFG_ERASE_CNT_B:   r_erase_cnt_b   <= i_cfg_data[15:0];
                CFG_ERASE_CNT_DEF: r_erase_cnt_def <= i_cfg_data[15:0];
                CFG_CLOSING_REPLY: r_closing_reply <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_phase        <= PH_HEADER;
            r_parse        <= PS_NAME;
            r_frame_offset <= '0;
            r_frame_type   <= '0;
            r_write_addr   <= '0;
            r_bytes_done   <= '0;
            r_file_size    <= '0;
            r_write_limit  <= '0;
            r_done         <= 1'b0;
        end else begin
            r_in_valid     <= in_accept;
            r_phase        <= n_phase;
            r_parse        <= n_parse;
            r_frame_offset <= n_frame_offset;
            r_frame_type   <= n_frame_type;
            r_write_addr   <= n_write_addr;
            r_bytes_done   <= n_bytes_done;
            r_file_size    <= n_file_size;
            r_write_limit  <= n_write_limit;
            r_done         <= n_done;
        end
    end

    a_abort_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.cmd) |=> (r_phase == PH_HEADER && !r_done
                                      && r_frame_offset == '0))
        else $error("abort did not return receiver to header phase");

    a_end_restarts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.frame_end) |=> (r_frame_offset == '0))
        else $error("frame offset not cleared after frame end");

    a_write_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        has_wr |-> (r_phase == PH_DATA && idx < r_write_limit))
        else $error("flash write outside data phase or past limit");

endmodule

### rtl/core/ymfr_outq.sv
// ymfr_outq: bundle queue and result serializer toward the output channel
// one result leaves per cycle while i_out_stall is low; depends on ymfr_pkg
module ymfr_outq import ymfr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_bundle             i_bundle,
    input  logic                i_out_stall,
    output logic [BQ_LVL_W-1:0] o_level,
    output logic                o_out_valid,
    output t_res                o_res,
    output logic                o_success,
    output logic                o_last
);

    t_bundle             r_q [BQ_DEPTH];
    logic [BQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [BQ_LVL_W-1:0] r_level;
    logic [NUM_W-1:0]    r_sub;
    t_bundle             head;
    logic                out_take;
    logic                pop;

    assign head        = r_q[r_rd_ptr];
    assign o_level     = r_level;
    assign o_out_valid = (r_level != '0);
    assign o_res       = head.res[r_sub];
    assign o_success   = head.success;
    assign o_last      = (r_sub == head.num - NUM_W'(1));
    assign out_take    = o_out_valid && !i_out_stall;
    assign pop         = out_take && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
            r_sub    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + BQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + BQ_PTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_level <= r_level + BQ_LVL_W'(1);
                2'b01:   r_level <= r_level - BQ_LVL_W'(1);
                default: r_level <= r_level;
            endcase
            if (out_take) begin
                r_sub <= o_last ? '0 : r_sub + NUM_W'(1);
            end
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= BQ_LVL_W'(BQ_DEPTH))
        else $error("bundle queue level out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == BQ_LVL_W'(BQ_DEPTH)) |-> !i_push)
        else $error("push into full bundle queue");

    a_nonempty_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_bundle.num != '0))
        else $error("empty bundle pushed");

endmodule

### tb/sv/tb_ymodem_frame_receiver_top.sv
`timescale 1ns / 1ps
// tb_ymodem_frame_receiver_top: self-checking bench for the ymodem frame receiver, a directed
// table of frames followed by random transfers under idle and stall, results checked in order
// depends on ymfr_pkg and ymodem_frame_receiver_top
module tb_ymodem_frame_receiver_top;
    import ymfr_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int CFG_GAP        = 4;
    localparam int END_WAIT       = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SECTION_ITEMS  = 60;
    localparam int REPORT_MAX     = 10;
    localparam logic [10:0] OFF_SAT = 11'h7FF;

    typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_EOT, PH_CLOSE} t_phase;
    typedef enum logic [1:0] {PARSE_NAME, PARSE_DIGITS, PARSE_DONE} t_parse;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [31:0] addr;
        logic [15:0] count;
        logic        success;
        logic        last;
    } t_action;

    typedef struct packed {
        logic       cmd;
        logic [7:0] b;
        logic       fe;
        logic       typed;
        t_action    want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd = 1'b0;
    logic [7:0]            i_rx_byte = '0;
    logic                  i_frame_end = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_kind;
    logic [7:0]            o_value;
    logic [31:0]           o_flash_addr;
    logic [15:0]           o_sector_count;
    logic                  o_success;
    logic                  o_last;

    ymodem_frame_receiver_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_flash_addr   (o_flash_addr),
        .o_sector_count (o_sector_count),
        .o_success      (o_success),
        .o_last         (o_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // register mirror
    logic [31:0] cfg_target = '0;
    logic [31:0] cfg_slot_a = '0;
    logic [31:0] cfg_slot_b = '0;
    logic [15:0] cfg_cnt_a = 16'd20;
    logic [15:0] cfg_cnt_b = 16'd20;
    logic [15:0] cfg_cnt_def = 16'd20;
    logic [7:0]  cfg_closing = 8'd24;

    // receiver state
    t_phase      rx_phase = PH_HEADER;
    t_parse      rx_parse = PARSE_NAME;
    logic [10:0] rx_off = '0;
    logic [10:0] rx_limit = '0;
    logic [7:0]  rx_type = '0;
    logic [31:0] rx_waddr = '0;
    logic [31:0] rx_done = '0;
    logic [31:0] rx_size = '0;
    logic        rx_success = 1'b0;

    t_action    step_acts[$];
    t_action    flash_ops_due[$];
    logic [7:0] frame_bytes[$];
    t_row       plan[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int transfers = 0;
    int aborts = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    function automatic t_action act(input logic [1:0] k, input logic [7:0] v,
                                    input logic [31:0] a, input logic [15:0] c);
        return '{k, v, a, c, rx_success, 1'b0};
    endfunction

    task automatic track_receiver(input logic cmd, input logic [7:0] b, input logic fe);
        logic [10:0] off;
        logic [31:0] idx;
        logic [31:0] rem;
        logic [31:0] blk;
        logic [15:0] cnt;
        step_acts.delete();
        if (cmd) begin
            rx_phase = PH_HEADER;
            rx_success = 1'b0;
            rx_done = '0;
            rx_off = '0;
            rx_parse = PARSE_NAME;
            rx_limit = '0;
            return;
        end
        off = rx_off;
        if (off == 0) begin
            rx_type = b;
            rx_limit = '0;
            if (rx_phase == PH_HEADER && b == B_SOH) begin
                rx_size = '0;
                rx_parse = PARSE_NAME;
            end
            if (rx_phase == PH_DATA && (b == B_SOH || b == B_STX)) begin
                blk = (b == B_SOH) ? 32'(SHORT_BLOCK) : 32'(LONG_BLOCK);
                rem = rx_size - rx_done;
                rx_limit = (rem < blk) ? rem[10:0] : blk[10:0];
            end
        end else if (off >= 3) begin
            idx = 32'(off) - 32'd3;
            if (rx_phase == PH_HEADER && rx_type == B_SOH) begin
                if (rx_parse == PARSE_NAME) begin
                    if (b == 8'h00 || idx >= 32'(NAME_SCAN_LIMIT))
                        rx_parse = PARSE_DIGITS;
                end else if (rx_parse == PARSE_DIGITS) begin
                    if (b >= CH_0 && b <= CH_9)
                        rx_size = rx_size * 32'd10 + 32'(b - CH_0);
                    else
                        rx_parse = PARSE_DONE;
                end
            end else if (rx_phase == PH_DATA && (rx_type == B_SOH || rx_type == B_STX)) begin
                if (idx < 32'(rx_limit)) begin
                    step_acts.push_back(act(KIND_WRITE, b, rx_waddr, 16'd0));
                    rx_waddr = rx_waddr + 32'd1;
                    rx_done = rx_done + 32'd1;
                end
            end
        end
        if (fe) begin
            case (rx_phase)
                PH_HEADER: begin
                    if (rx_type == B_SOH) begin
                        rx_waddr = cfg_target;
                        rx_done = '0;
                        if (cfg_target == cfg_slot_a)
                            cnt = cfg_cnt_a;
                        else if (cfg_target == cfg_slot_b)
                            cnt = cfg_cnt_b;
                        else
                            cnt = cfg_cnt_def;
                        step_acts.push_back(act(KIND_ERASE, 8'h00, cfg_target, cnt));
                        step_acts.push_back(act(KIND_REPLY, B_ACK, '0, '0));
                        step_acts.push_back(act(KIND_REPLY, B_C, '0, '0));
                        rx_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (rx_type == B_SOH || rx_type == B_STX) begin
                        step_acts.push_back(act(KIND_REPLY, B_ACK, '0, '0));
                    end else if (rx_type == B_EOT) begin
                        step_acts.push_back(act(KIND_REPLY, B_NAK, '0, '0));
                        rx_phase = PH_EOT;
                    end else begin
                        rx_phase = PH_HEADER;
                        rx_success = 1'b0;
                    end
                end
                PH_EOT: begin
                    if (rx_type == B_EOT) begin
                        rx_success = 1'b1;
                        step_acts.push_back(act(KIND_REPLY, B_ACK, '0, '0));
                        step_acts.push_back(act(KIND_REPLY, B_C, '0, '0));
                        rx_phase = PH_CLOSE;
                    end
                end
                default: begin
                    if (rx_type == B_SOH) begin
                        step_acts.push_back(act(KIND_REPLY, B_ACK, '0, '0));
                        step_acts.push_back(act(KIND_REPLY, cfg_closing, '0, '0));
                    end
                    rx_phase = PH_HEADER;
                end
            endcase
            rx_off = '0;
        end else if (off < OFF_SAT) begin
            rx_off = off + 11'd1;
        end
        if (step_acts.size() > 0)
            step_acts[step_acts.size()-1].last = 1'b1;
    endtask

    task automatic put_item(input logic cmd, input logic [7:0] b, input logic fe,
                            input logic typed, input t_action want);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_rx_byte <= b;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_in_stall);
        track_receiver(cmd, b, fe);
        if (typed)
            step_acts[0] = want;
        foreach (step_acts[i])
            flash_ops_due.push_back(step_acts[i]);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (flash_ops_due.size() != 0)
            @(posedge i_clk);
        repeat (CFG_GAP) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TARGET_ADDR:   cfg_target = data;
            CFG_SLOT_A_ADDR:   cfg_slot_a = data;
            CFG_SLOT_B_ADDR:   cfg_slot_b = data;
            CFG_ERASE_CNT_A:   cfg_cnt_a = data[15:0];
            CFG_ERASE_CNT_B:   cfg_cnt_b = data[15:0];
            CFG_ERASE_CNT_DEF: cfg_cnt_def = data[15:0];
            CFG_CLOSING_REPLY: cfg_closing = data[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic start_frame(input logic [7:0] t, input logic [7:0] seq);
        frame_bytes.delete();
        frame_bytes.push_back(t);
        frame_bytes.push_back(seq);
        frame_bytes.push_back(~seq);
    endtask

    // sends frame_bytes, closing the frame on the last byte, or cuts it with an abort
    task automatic send_frame(input int abort_pct, output bit aborted);
        int cut;
        aborted = 1'b0;
        cut = frame_bytes.size();
        if ($urandom_range(99) < abort_pct) begin
            cut = $urandom_range(frame_bytes.size() - 1);
            aborted = 1'b1;
        end
        for (int i = 0; i < cut; i++)
            put_item(1'b0, frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
        if (aborted) begin
            put_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            aborts++;
        end
    endtask

    task automatic junk_frame();
        logic [7:0] t;
        bit ab;
        do t = 8'($urandom_range(255)); while (t == B_SOH);
        frame_bytes.delete();
        frame_bytes.push_back(t);
        repeat ($urandom_range(4)) frame_bytes.push_back(8'($urandom_range(255)));
        send_frame(20, ab);
    endtask

    task automatic random_transfer(input bit giant);
        bit ab;
        int fsize;
        int len;
        int nframes;
        logic [7:0] t;
        string digits;
        // header: name, terminator, size digits, non-digit, padding
        start_frame(B_SOH, 8'h00);
        len = ($urandom_range(11) == 0) ? 130 : $urandom_range(6);
        repeat (len) frame_bytes.push_back(8'($urandom_range(1, 255)));
        frame_bytes.push_back(8'h00);
        if (!giant && $urandom_range(9) == 0) begin
            repeat ($urandom_range(10, 11)) frame_bytes.push_back(8'($urandom_range(CH_0, CH_9)));
        end else begin
            fsize = giant ? 1500 : $urandom_range(200);
            digits = $sformatf("%0d", fsize);
            for (int i = 0; i < digits.len(); i++)
                frame_bytes.push_back(digits[i]);
        end
        frame_bytes.push_back(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(8'h3A, 8'hFF)));
        repeat ($urandom_range(3)) frame_bytes.push_back(8'($urandom_range(255)));
        if (!giant && $urandom_range(9) == 0) begin
            len = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > len)
                void'(frame_bytes.pop_back());
        end
        send_frame(giant ? 0 : 3, ab);
        if (ab)
            return;
        // data
        nframes = 0;
        while (nframes < 2 && (giant || rx_size != rx_done || $urandom_range(3) == 0)) begin
            if (!giant && $urandom_range(14) == 0) begin
                do t = 8'($urandom_range(255));
                while (t == B_SOH || t == B_STX || t == B_EOT);
                start_frame(t, 8'($urandom_range(255)));
                send_frame(0, ab);
                return;
            end
            if (giant && nframes == 0) begin
                t = B_STX;
                len = 2060;
            end else begin
                t = ($urandom_range(1) == 0) ? B_SOH : B_STX;
                len = ($urandom_range(9) == 0) ? $urandom_range(120, 136) : $urandom_range(24);
            end
            start_frame(t, 8'($urandom_range(255)));
            repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
            if (!giant && $urandom_range(11) == 0)
                void'(frame_bytes.pop_back());
            send_frame(giant ? 0 : 3, ab);
            if (ab)
                return;
            nframes++;
        end
        // end of file, with a stray frame now and then after the first EOT
        frame_bytes.delete();
        frame_bytes.push_back(B_EOT);
        send_frame(2, ab);
        if (ab)
            return;
        if ($urandom_range(4) == 0) begin
            do t = 8'($urandom_range(255)); while (t == B_EOT);
            start_frame(t, 8'($urandom_range(255)));
            send_frame(0, ab);
        end
        frame_bytes.delete();
        frame_bytes.push_back(B_EOT);
        send_frame(2, ab);
        if (ab)
            return;
        start_frame(($urandom_range(7) == 0) ? B_STX : B_SOH, 8'h00);
        repeat ($urandom_range(3)) frame_bytes.push_back(8'h00);
        send_frame(0, ab);
        transfers++;
    endtask

    // result checker
    t_action got;
    t_action want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_kind, o_value, o_flash_addr, o_sector_count, o_success, o_last};
            results_seen++;
            if (flash_ops_due.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result kind=%0d value=%h addr=%h count=%0d succ=%b last=%b",
                             got.kind, got.value, got.addr, got.count, got.success, got.last);
                mismatches++;
            end else begin
                want = flash_ops_due.pop_front();
                if (got !== want) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("mismatch exp kind=%0d value=%h addr=%h count=%0d succ=%b last=%b",
                                 want.kind, want.value, want.addr, want.count, want.success,
                                 want.last);
                        $display("         got kind=%0d value=%h addr=%h count=%0d succ=%b last=%b",
                                 got.kind, got.value, got.addr, got.count, got.success, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ymodem_frame_receiver_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sent_base;
        // header with name and size 5, one long data frame, both EOTs, closing header
        plan.push_back('{1'b0, B_SOH, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h61, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h35, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h20, 1'b1, 1'b1,
                         '{KIND_ERASE, 8'h00, 32'h0, 16'd20, 1'b0, 1'b0}});
        plan.push_back('{1'b0, B_STX, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h01, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'hFE, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'hFF, 1'b0, 1'b1,
                         '{KIND_WRITE, 8'hFF, 32'h0, 16'd0, 1'b0, 1'b1}});
        plan.push_back('{1'b0, 8'h00, 1'b0, 1'b1,
                         '{KIND_WRITE, 8'h00, 32'h1, 16'd0, 1'b0, 1'b1}});
        plan.push_back('{1'b0, 8'hA5, 1'b1, 1'b0, '0});
        plan.push_back('{1'b0, B_EOT, 1'b1, 1'b1,
                         '{KIND_REPLY, B_NAK, 32'h0, 16'd0, 1'b0, 1'b1}});
        plan.push_back('{1'b0, B_EOT, 1'b1, 1'b1,
                         '{KIND_REPLY, B_ACK, 32'h0, 16'd0, 1'b1, 1'b0}});
        plan.push_back('{1'b0, B_SOH, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, 8'hFF, 1'b1, 1'b1,
                         '{KIND_REPLY, B_ACK, 32'h0, 16'd0, 1'b1, 1'b0}});
        // abort, empty header, unknown data frame, stray frame, abort mid header
        plan.push_back('{1'b1, 8'hFF, 1'b1, 1'b0, '0});
        plan.push_back('{1'b0, B_SOH, 1'b1, 1'b1,
                         '{KIND_ERASE, 8'h00, 32'h0, 16'd20, 1'b0, 1'b0}});
        plan.push_back('{1'b0, 8'h55, 1'b1, 1'b0, '0});
        plan.push_back('{1'b0, B_STX, 1'b1, 1'b0, '0});
        plan.push_back('{1'b0, B_SOH, 1'b0, 1'b0, '0});
        plan.push_back('{1'b1, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{1'b0, CH_9, 1'b1, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i])
            put_item(plan[i].cmd, plan[i].b, plan[i].fe, plan[i].typed, plan[i].want);

        for (int sec = 0; sec < 4; sec++) begin
            settle();
            case (sec)
                0: begin
                    set_reg(CFG_TARGET_ADDR, 32'h0800_4000);
                    set_reg(CFG_SLOT_A_ADDR, 32'h0800_4000);
                    set_reg(CFG_SLOT_B_ADDR, 32'h0802_0000);
                    set_reg(CFG_ERASE_CNT_A, 32'h0000_0000);
                    set_reg(CFG_ERASE_CNT_B, 32'h0000_FFFF);
                    set_reg(CFG_ERASE_CNT_DEF, 32'd7);
                    set_reg(CFG_CLOSING_REPLY, 32'h0000_00FF);
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    set_reg(CFG_TARGET_ADDR, 32'h0802_0000);
                    set_reg(CFG_CLOSING_REPLY, 32'h0000_0000);
                    idle_pct = 57;
                    stall_pct = 0;
                end
                2: begin
                    set_reg(CFG_TARGET_ADDR, 32'hFFFF_FFFF);
                    set_reg(CFG_SLOT_A_ADDR, 32'h0000_0000);
                    set_reg(CFG_ERASE_CNT_DEF, 32'h0000_FFFF);
                    set_reg(CFG_CLOSING_REPLY, 32'd24);
                    idle_pct = 0;
                    stall_pct = 57;
                end
                default: begin
                    set_reg(CFG_SLOT_A_ADDR, $urandom);
                    set_reg(CFG_SLOT_B_ADDR, $urandom);
                    set_reg(CFG_TARGET_ADDR, ($urandom_range(1) == 0) ? cfg_slot_a : $urandom);
                    set_reg(CFG_ERASE_CNT_A, $urandom_range(16'hFFFF));
                    set_reg(CFG_ERASE_CNT_B, $urandom_range(16'hFFFF));
                    set_reg(CFG_ERASE_CNT_DEF, $urandom_range(16'hFFFF));
                    set_reg(CFG_CLOSING_REPLY, $urandom_range(255));
                    idle_pct = 21;
                    stall_pct = 21;
                end
            endcase
            i_cfg_we <= 1'b0;
            sent_base = items_sent;
            while (items_sent - sent_base < SECTION_ITEMS) begin
                if ($urandom_range(4) == 0)
                    junk_frame();
                random_transfer(1'b0);
                if ($urandom_range(5) == 0)
                    settle();
            end
        end

        settle();
        repeat (END_WAIT) @(posedge i_clk);
        if (flash_ops_due.size() != 0) begin
            $display("%0d expected results never arrived", flash_ops_due.size());
            mismatches++;
        end
        $display("run: %0d requests, %0d results checked, %0d complete transfers, %0d aborts",
                 items_sent, results_seen, transfers, aborts);
        $display("     four idle/stall mixes, slot A/B/default erase, 11 digit size wrap");
        if (mismatches == 0) begin
            $display("ymodem_frame_receiver_top test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("ymodem_frame_receiver_top test failed");
        end
        $finish;
    end

endmodule
